[rtl/windowed_frame_rate_meter_defines.svh]
// Assertion macros shared by the frame rate meter RTL.
`ifndef WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define WFRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define WFRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/wfrm_pkg.sv]
// Shared constants, types and state encodings of the frame rate meter.
package wfrm_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned TGT_W      = 17;
  localparam int unsigned SLOTS_W    = 9;
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned RING_AW    = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned TDATA_IN_W  = 48;
  localparam int unsigned TDATA_OUT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

  // Window derived from the reset target of 24.00 fps.
  localparam logic [WIN_W-1:0]   DERIV_RST = 8'd24;
  localparam logic [SLOTS_W-1:0] SLOTS_RST = 9'd25;
  localparam logic [WIN_W-1:0]   WIN_CAP   = 8'd255;

  // ceil(2^24 / 100); low product bits tell exact multiples of 100 apart
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP       = 18'd167773;
  localparam int unsigned PROD_W      = 35;

  // Serial divider: (count-1) * 1e8 over the span.
  localparam int unsigned NUM_W     = 35;
  localparam logic [26:0] SCALE     = 27'd100000000;
  localparam int unsigned STEP_W    = 6;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              rate_valid;
    logic [CNT_W-1:0]  intervals;
    logic [TIME_W-1:0] span;
    logic              frac;
  } job_t;

  typedef enum logic {
    FR_IDLE,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_e;

endpackage

[rtl/windowed_frame_rate_meter.sv]
// Windowed frame rate meter top level.
// Each beat on the input stream is either a frame timestamp in microseconds
// (tuser low) or a clear command (tuser high); every beat yields exactly one
// result beat carrying the averaged rate in hundredths of fps over the last
// window+1 stamps, a valid flag and the fractional-target flag. The front
// end takes one beat at a time and takes no new beat until its job is in
// the two-entry queue; the back end resolves clears, short windows and zero
// spans directly and otherwise runs a 35-step restoring divider, which sets
// the sustained rate for timestamp beats with a nonzero span.
// Configuration writes empty the ring; no clearing pass is needed after
// reset.
module windowed_frame_rate_meter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wfrm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wfrm_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [47:0] timestamp_us
  input  logic [wfrm_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  // [0] op (1 = clear)
  input  logic [0:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [23:0] rate_centi_fps, [24] target_fractional, [31:25] zero
  output logic [wfrm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  // [0] rate_valid
  output logic [0:0]                         m_axis_tuser_o
);
  import wfrm_pkg::*;

  logic              push, full, pop, avail;
  job_t              push_data, pop_data;
  logic [RATE_W-1:0] rate;
  logic              rate_valid, frac;

  wfrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_clear_i  (s_axis_tuser_i[0]),
    .in_stamp_i  (s_axis_tdata_i[TIME_W-1:0]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  wfrm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .avail_o     (avail)
  );

  wfrm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (avail),
    .job_i            (pop_data),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_rate_o       (rate),
    .out_rate_valid_o (rate_valid),
    .out_frac_o       (frac)
  );

  assign m_axis_tdata_o = {(TDATA_OUT_W - RATE_W - 1)'(0), frac, rate};
  assign m_axis_tuser_o = rate_valid;

endmodule

[rtl/wfrm_front.sv]
// Front end: configuration registers, timestamp ring and span extraction.
`include "windowed_frame_rate_meter_defines.svh"

module wfrm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wfrm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wfrm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_clear_i,
  input  logic [wfrm_pkg::TIME_W-1:0]     in_stamp_i,
  output logic                            push_o,
  output wfrm_pkg::job_t                  push_data_o,
  input  logic                            full_i
);
  import wfrm_pkg::*;

  front_state_e state_q, state_d;

  logic [WIN_W-1:0]   win_q;
  logic [WIN_W-1:0]   deriv_q;
  logic               frac_q;
  logic [SLOTS_W-1:0] slots_q;
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [SLOTS_W-1:0] fill_q, fill_d;

  logic [TIME_W-1:0]  ring_q [RING_DEPTH];
  logic [TIME_W-1:0]  rd_q;
  logic [TIME_W-1:0]  newest_q;
  logic               jvld_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [PROD_W-1:0]  prod;
  logic [11:0]        ceil_q;
  logic               new_frac;
  logic [WIN_W-1:0]   new_deriv;
  logic               accept, rec;
  logic [SLOTS_W-1:0] wp_inc;
  logic [RING_AW-1:0] rd_addr;

  // ceil(target / 100) and fractional flag by reciprocal multiplication
  assign prod      = PROD_W'(cfg_data_i[TGT_W-1:0]) * PROD_W'(RECIP);
  assign new_frac  = |prod[RECIP_SHIFT-1:TGT_W];
  assign ceil_q    = {1'b0, prod[PROD_W-1:RECIP_SHIFT]} + 12'(new_frac);
  assign new_deriv = (ceil_q == '0) ? WIN_W'(1) :
                     (ceil_q > 12'(WIN_CAP)) ? WIN_CAP : ceil_q[WIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      deriv_q <= DERIV_RST;
      frac_q  <= 1'b0;
      slots_q <= SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: begin
          win_q   <= cfg_data_i[WIN_W-1:0];
          slots_q <= (cfg_data_i[WIN_W-1:0] != '0) ?
                     {1'b0, cfg_data_i[WIN_W-1:0]} + SLOTS_W'(1) :
                     {1'b0, deriv_q} + SLOTS_W'(1);
        end
        CFG_TARGET: begin
          deriv_q <= new_deriv;
          frac_q  <= new_frac;
          slots_q <= (win_q != '0) ? {1'b0, win_q} + SLOTS_W'(1) :
                     {1'b0, new_deriv} + SLOTS_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == FR_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rec        = accept && !in_clear_i;
  assign wp_inc     = {1'b0, wp_q} + SLOTS_W'(1);

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    push_o  = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          state_d = FR_PUSH;
          if (in_clear_i) begin
            wp_d   = '0;
            fill_d = '0;
          end else begin
            wp_d   = (wp_inc == slots_q) ? '0 : wp_inc[RING_AW-1:0];
            fill_d = (fill_q < slots_q) ? fill_q + SLOTS_W'(1) : fill_q;
          end
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
    if (cfg_we_i && (cfg_idx_i == CFG_WINDOW || cfg_idx_i == CFG_TARGET)) begin
      wp_d   = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
    end
  end

  // oldest held stamp: slot 0 while filling, else the slot written next
  assign rd_addr = (fill_d < slots_q) ? '0 : wp_d;

  always_ff @(posedge clk_i) begin
    if (rec) begin
      ring_q[wp_q] <= in_stamp_i;
    end
    if (accept) begin
      rd_q     <= ring_q[rd_addr];
      newest_q <= in_stamp_i;
      jvld_q   <= !in_clear_i && (fill_d >= SLOTS_W'(2));
      cnt_q    <= CNT_W'(fill_d - SLOTS_W'(1));
    end
  end

  assign push_data_o.rate_valid = jvld_q;
  assign push_data_o.intervals  = cnt_q;
  assign push_data_o.span       = newest_q - rd_q;
  assign push_data_o.frac       = frac_q;

  `WFRM_ASSERT(a_fill_le_slots, fill_q <= slots_q, "fill count exceeds ring size")
  `WFRM_ASSERT(a_wp_in_ring, {1'b0, wp_q} < slots_q, "write position outside ring")
  `WFRM_ASSERT_IMP(a_slots_min, 1'b1, slots_q >= SLOTS_W'(2), "ring shorter than two slots")

endmodule

[rtl/wfrm_queue.sv]
// Two-entry job queue between the front end and the divider.
module wfrm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wfrm_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output wfrm_pkg::job_t  pop_data_o,
  output logic            avail_o
);
  import wfrm_pkg::*;

  job_t       slot_q [QUEUE_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(QUEUE_DEPTH));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[rtl/wfrm_back.sv]
// Back end: serial rate divider, saturation and output register.
`include "windowed_frame_rate_meter_defines.svh"

module wfrm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             avail_i,
  input  wfrm_pkg::job_t                   job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wfrm_pkg::RATE_W-1:0]      out_rate_o,
  output logic                             out_rate_valid_o,
  output logic                             out_frac_o
);
  import wfrm_pkg::*;

  back_state_e state_q, state_d;

  logic [NUM_W-1:0]  num_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] span_q;
  logic [STEP_W-1:0] step_q;
  logic              frac_q;

  logic              ovld_q, ovld_d;
  logic [RATE_W-1:0] orate_q;
  logic              oflag_q, ofrac_q;

  logic              out_free, trivial, load, start, step;
  logic [RATE_W-1:0] load_rate;
  logic              load_flag, load_frac;
  logic [TIME_W:0]   trial;
  logic              ge;
  logic [TIME_W:0]   diff;

  assign out_free = !ovld_q || out_ready_i;
  assign trivial  = !job_i.rate_valid || (job_i.span == '0);

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    start     = 1'b0;
    step      = 1'b0;
    load_rate = '0;
    load_flag = job_i.rate_valid;
    load_frac = job_i.frac;
    case (state_q)
      BK_IDLE: begin
        if (avail_i) begin
          if (trivial) begin
            if (out_free) begin
              pop_o = 1'b1;
              load  = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            start   = 1'b1;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        step = 1'b1;
        if (step_q == '0) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        load_flag = 1'b1;
        load_frac = frac_q;
        load_rate = (|num_q[NUM_W-1:RATE_W]) ? RATE_MAX : num_q[RATE_W-1:0];
        if (out_free) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, span_q};
  assign ge    = (trial >= {1'b0, span_q});

  always_ff @(posedge clk_i) begin
    if (start) begin
      num_q  <= NUM_W'(job_i.intervals) * NUM_W'(SCALE);
      rem_q  <= '0;
      span_q <= job_i.span;
      frac_q <= job_i.frac;
      step_q <= DIV_LAST;
    end else if (step) begin
      num_q  <= {num_q[NUM_W-2:0], ge};
      rem_q  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      if (step_q != '0) begin
        step_q <= step_q - STEP_W'(1);
      end
    end
    if (load) begin
      orate_q <= load_rate;
      oflag_q <= load_flag;
      ofrac_q <= load_frac;
    end
  end

  always_comb begin
    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o      = ovld_q;
  assign out_rate_o       = orate_q;
  assign out_rate_valid_o = oflag_q;
  assign out_frac_o       = ofrac_q;

  `WFRM_ASSERT_IMP(a_div_span_nz, state_q == BK_DIV, span_q != '0, "divide by zero span")
  `WFRM_ASSERT_IMP(a_fin_done, state_q == BK_FIN, step_q == '0, "divider left early")
  `WFRM_ASSERT_IMP(a_invalid_zero, ovld_q && !oflag_q, orate_q == '0, "invalid rate nonzero")
  `WFRM_ASSERT_IMP(a_pop_avail, pop_o, avail_i, "pop from empty queue")

endmodule
